/* src/amt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// amt_pkg: shared types for the anagram match table
// Holds the sorter cell control struct and the field widths of the streams.
// ---------------------------------------------------------------------------
package amt_pkg;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 5;

    // Control handed down the sorter cell chain
    typedef struct packed {
        logic clear;   // empty the cell
        logic insert;  // take part in an insertion
    } t_cell_ctl;
endpackage
`default_nettype wire

/* src/amt_sort_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// amt_sort_cell: one cell of the insertion sorter
// Keeps one byte of the sorted word. On insert, a cell whose byte is greater
// than the new byte takes its left neighbor's byte (or the new byte), so the
// row stays sorted ascending, with empty cells acting as +infinity.
// ---------------------------------------------------------------------------
module amt_sort_cell (
    input  wire logic                        i_clk,
    input  wire amt_pkg::t_cell_ctl          i_ctl,
    input  wire logic [amt_pkg::CHAR_W-1:0]  i_new,
    input  wire logic [amt_pkg::CHAR_W-1:0]  i_left_val,
    input  wire logic                        i_left_full,
    input  wire logic                        i_left_gt,
    output logic [amt_pkg::CHAR_W-1:0]       o_val,
    output logic                             o_full,
    output logic                             o_gt
);
    logic [amt_pkg::CHAR_W-1:0] r_val;
    logic                       r_full;

    assign o_val  = r_val;
    assign o_full = r_full;
    // empty cells sort after every byte
    assign o_gt   = !r_full || (r_val > i_new);

    // shift or insert on a new byte; an empty cell behind another empty
    // cell stays empty
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_full <= 1'b0;
        end else if (i_ctl.insert && o_gt && (i_left_full || !i_left_gt)) begin
            r_full <= 1'b1;
            if (i_left_gt && i_left_full) begin
                r_val <= i_left_val;
            end else begin
                r_val <= i_new;
            end
        end
    end
endmodule
`default_nettype wire

/* src/anagram_match_table_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// anagram_match_table_unit: anagram dictionary lookup
// Collects words a byte at a time, stores sorted load words, reports matches.
// ---------------------------------------------------------------------------
// Input channel s_axis: one byte per transaction; tuser = req_type (0 load,
// 1 query), tlast = word_end. A row of sorter cells keeps the current word
// sorted as it arrives.
// On a load word_end the sorted row is written into the dictionary memory,
// one byte per cycle. On a query word_end the block walks each stored
// entry, comparing one byte per cycle and then deciding on the entry; each
// match is sent on m_axis as a transaction with tdata = entry_index,
// tuser = found, tlast = last_result. A match is held until the next one
// is known, so a final match is sent from a separate flush step. A query
// without a match gives one not-found transaction. Input is held off
// during the store and the walk.
// A stalled receiver holds the output register and halts the walk.
// Reset empties the dictionary and the word buffer; no clearing pass.
// ---------------------------------------------------------------------------
module anagram_match_table_unit #(
    parameter int ENTRIES      = 32,
    parameter int MAX_WORD_LEN = 50
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  wire logic       s_axis_tuser,   // [0] req_type
    input  wire logic       s_axis_tlast,   // word_end
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [4:0] entry_index, [7:5] zero
    output logic            m_axis_tuser,   // [0] found
    output logic            m_axis_tlast    // last_result
);
    localparam int LW = $clog2(MAX_WORD_LEN + 1);
    localparam int PW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int EW = $clog2(ENTRIES + 1);
    localparam int XW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DEPTH = ENTRIES * MAX_WORD_LEN;
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_COLLECT = 4'b0001,
        ST_STORE   = 4'b0010,
        ST_SCAN    = 4'b0100,
        ST_EMIT    = 4'b1000
    } t_state;

    t_state                  r_state;
    logic [LW-1:0]           r_len;
    logic [EW-1:0]           r_count;
    logic [XW-1:0]           r_entry;
    logic [LW-1:0]           r_pos;
    logic                    r_eq;
    logic                    r_pend;
    logic                    r_flush;
    logic [XW-1:0]           r_pend_idx;
    logic [7:0]              r_mem [DEPTH];
    logic [7:0]              r_rd;
    logic [LW-1:0]           r_elen [ENTRIES];
    logic                    r_rd_ok;
    logic [PW-1:0]           r_rd_pos;
    logic                    r_ov;
    logic [XW-1:0]           r_ov_idx;
    logic                    r_ov_found;
    logic                    r_ov_last;

    amt_pkg::t_cell_ctl      w_ctl;
    logic [7:0]              w_val  [MAX_WORD_LEN];
    logic                    w_full [MAX_WORD_LEN];
    logic                    w_gt   [MAX_WORD_LEN];
    logic                    w_acc;
    logic                    w_out_free;
    logic                    w_hit;
    logic                    w_done;
    logic                    w_finish;

    assign w_out_free    = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == ST_COLLECT);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // match decision for the entry just compared
    assign w_hit    = r_eq && (r_elen[r_entry] == r_len) && (EW'(r_entry) < r_count);
    assign w_done   = (EW'(r_entry) + EW'(1) >= r_count);
    assign w_finish = (r_state == ST_EMIT) && w_out_free &&
                      (r_flush || (w_done && !w_hit));

    // drive the sorter chain: insert while room, clear on reset and after a word ends
    assign w_ctl.insert = w_acc && (r_len < LW'(MAX_WORD_LEN));
    assign w_ctl.clear  = !i_rst_n ||
        ((r_state == ST_STORE) && (r_pos == LW'(MAX_WORD_LEN - 1))) ||
        w_finish;

    genvar g;
    generate
        for (g = 0; g < MAX_WORD_LEN; g++) begin : g_cell
            if (g == 0) begin : g_first
                amt_sort_cell u_cell (
                    .i_clk(i_clk), .i_ctl(w_ctl), .i_new(s_axis_tdata),
                    .i_left_val(8'd0), .i_left_full(1'b0), .i_left_gt(1'b0),
                    .o_val(w_val[g]), .o_full(w_full[g]), .o_gt(w_gt[g]));
            end else begin : g_rest
                amt_sort_cell u_cell (
                    .i_clk(i_clk), .i_ctl(w_ctl), .i_new(s_axis_tdata),
                    .i_left_val(w_val[g-1]), .i_left_full(w_full[g-1]),
                    .i_left_gt(w_gt[g-1]),
                    .o_val(w_val[g]), .o_full(w_full[g]), .o_gt(w_gt[g]));
            end
        end
    endgenerate

    // dictionary memory: write the sorted row during store, read during scan
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic [PW-1:0] w_pos_i;
    assign w_pos_i   = r_pos[PW-1:0];
    assign w_wr_addr = AW'(r_count[XW-1:0]) * AW'(MAX_WORD_LEN) + AW'(w_pos_i);
    assign w_rd_addr = AW'(r_entry) * AW'(MAX_WORD_LEN) + AW'(w_pos_i);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_STORE && r_count < EW'(ENTRIES)) begin
            r_mem[w_wr_addr] <= w_val[w_pos_i];
        end
        r_rd <= r_mem[w_rd_addr];
        if (r_state == ST_COLLECT && w_acc && s_axis_tlast && !s_axis_tuser
            && r_count < EW'(ENTRIES)) begin
            r_elen[r_count[XW-1:0]] <= (r_len < LW'(MAX_WORD_LEN)) ?
                                       r_len + LW'(1) : r_len;
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_len   <= '0;
            r_count <= '0;
            r_pos   <= '0;
            r_entry <= '0;
            r_rd_ok <= 1'b0;
            r_eq    <= 1'b1;
            r_pend  <= 1'b0;
            r_flush <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_rd_pos <= w_pos_i;
            unique case (r_state)
                ST_COLLECT: begin
                    if (w_acc) begin
                        if (w_ctl.insert) r_len <= r_len + LW'(1);
                        if (s_axis_tlast) begin
                            r_pos   <= '0;
                            r_entry <= '0;
                            r_eq    <= 1'b1;
                            r_pend  <= 1'b0;
                            r_flush <= 1'b0;
                            r_state <= s_axis_tuser ? ST_SCAN : ST_STORE;
                        end
                    end
                end
                ST_STORE: begin
                    r_pos <= r_pos + LW'(1);
                    if (r_pos == LW'(MAX_WORD_LEN - 1)) begin
                        if (r_count < EW'(ENTRIES)) r_count <= r_count + EW'(1);
                        r_len   <= '0;
                        r_state <= ST_COLLECT;
                    end
                end
                ST_SCAN: begin
                    // issue reads, compare one byte a cycle
                    if (r_pos < LW'(MAX_WORD_LEN)) begin
                        r_pos   <= r_pos + LW'(1);
                        r_rd_ok <= (r_pos < r_len);
                    end
                    if (r_rd_ok && r_rd != w_val[r_rd_pos]) r_eq <= 1'b0;
                    if (r_pos == LW'(MAX_WORD_LEN) && !r_rd_ok) begin
                        r_state <= ST_EMIT;
                    end
                    if (EW'(r_entry) >= r_count) begin
                        r_state <= ST_EMIT;
                        r_eq    <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    // hold the previous match until the next is known
                    if (w_out_free) begin
                        if (r_flush) begin
                            // send the held match as the final one
                            r_ov       <= 1'b1;
                            r_ov_idx   <= r_pend_idx;
                            r_ov_found <= 1'b1;
                            r_ov_last  <= 1'b1;
                            r_pend     <= 1'b0;
                            r_flush    <= 1'b0;
                            r_len      <= '0;
                            r_entry    <= '0;
                            r_state    <= ST_COLLECT;
                        end else begin
                            if (r_pend && w_hit) begin
                                r_ov       <= 1'b1;
                                r_ov_idx   <= r_pend_idx;
                                r_ov_found <= 1'b1;
                                r_ov_last  <= 1'b0;
                            end
                            if (w_hit) begin
                                r_pend     <= 1'b1;
                                r_pend_idx <= r_entry;
                            end
                            if (w_done) begin
                                r_entry <= '0;
                                if (w_hit) begin
                                    r_flush <= 1'b1;
                                end else begin
                                    r_ov       <= 1'b1;
                                    r_ov_last  <= 1'b1;
                                    r_ov_found <= r_pend;
                                    r_ov_idx   <= r_pend ? r_pend_idx : '0;
                                    r_pend     <= 1'b0;
                                    r_len      <= '0;
                                    r_state    <= ST_COLLECT;
                                end
                            end else begin
                                r_entry <= r_entry + XW'(1);
                                r_pos   <= '0;
                                r_eq    <= 1'b1;
                                r_state <= ST_SCAN;
                            end
                        end
                    end
                end
                default: r_state <= ST_COLLECT;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {3'b000, 5'(r_ov_idx)};
    assign m_axis_tuser  = r_ov_found;
    assign m_axis_tlast  = r_ov_last;

    // output held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
        $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");
    // no input taken outside collection
    a_noin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_COLLECT |-> !s_axis_tready)
        else $error("input ready during walk");
    // a not-found result is always last
    a_nf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("not-found result not last");
    // count never exceeds capacity
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= EW'(ENTRIES))
        else $error("entry count overflow");
endmodule
`default_nettype wire

/* sim/anagram_match_table_unit_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// anagram_match_table_unit_test: self-checking bench for the anagram table
// Streams load and query words with bursty input and a stalling receiver;
// a scoreboard keeps a sorted-word dictionary and predicts every match.
// ---------------------------------------------------------------------------
module anagram_match_table_unit_test;
    localparam int ENTRIES      = 32;
    localparam int MAX_WORD_LEN = 50;
    localparam bit REQ_LOAD     = 1'b0;
    localparam bit REQ_QUERY    = 1'b1;
    localparam int TAIL_CYCLES  = ENTRIES * (MAX_WORD_LEN + 4) + 200;

    typedef struct packed {
        logic [amt_pkg::IDX_W-1:0] entry_index;
        logic                      found;
        logic                      last_result;
    } t_match;

    // Dictionary mirror and match predictor
    class anagram_scoreboard;
        byte unsigned dict_words[$][$];
        byte unsigned word_buf[$];
        t_match       pending[$];
        int           errors;

        function void note_char(bit req, byte unsigned ch, bit word_end);
            byte unsigned srt[$];
            int           hits;
            t_match       m;
            if (word_buf.size() < MAX_WORD_LEN) word_buf.push_back(ch);
            if (!word_end) return;
            srt = word_buf;
            srt.sort();
            word_buf.delete();
            if (req == REQ_LOAD) begin
                if (dict_words.size() < ENTRIES) dict_words.push_back(srt);
                return;
            end
            hits = 0;
            foreach (dict_words[j]) begin
                if (dict_words[j] == srt) begin
                    m.entry_index = j[amt_pkg::IDX_W-1:0];
                    m.found       = 1'b1;
                    m.last_result = 1'b0;
                    pending.push_back(m);
                    hits++;
                end
            end
            if (hits == 0) begin
                m = '0;
                m.last_result = 1'b1;
                pending.push_back(m);
            end else begin
                pending[pending.size()-1].last_result = 1'b1;
            end
        endfunction

        function void check_match(logic [7:0] data, logic user, logic last);
            t_match m;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result idx=%0d found=%0b last=%0b",
                         $realtime, data, user, last);
                errors++;
                return;
            end
            m = pending.pop_front();
            if (data !== {3'b000, m.entry_index} || user !== m.found ||
                last !== m.last_result) begin
                $display("%0t: mismatch expected idx=%0d found=%0b last=%0b, actual idx=%0d found=%0b last=%0b",
                         $realtime, m.entry_index, m.found, m.last_result, data, user, last);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // [7:0] char_code
    logic       s_axis_tuser = 1'b0; // [0] req_type
    logic       s_axis_tlast = 1'b0; // word_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;        // [4:0] entry_index
    logic       m_axis_tuser;        // [0] found
    logic       m_axis_tlast;        // last_result

    anagram_scoreboard sb = new();
    int  stall_mode = 0;
    int  hold_off = 0;
    int  burst_left = 0;
    int  fill_chars = 0;
    byte unsigned pool[$][$];

    anagram_match_table_unit u_dut (.*);

    always #4 i_clk = ~i_clk;

    // Check each output transaction at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_match(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Receiver stall pattern, with one long hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(3) != 0);
                default: m_axis_tready <= ($urandom_range(3) == 0);
            endcase
        end
    end

    // Drive one character, with bursts and gaps on the sender side
    task automatic send_char(bit req, byte unsigned ch, bit word_end);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(4);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= word_end;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_char(req, ch, word_end);
        @(negedge i_clk);
    endtask

    // Drop the input valid and idle the sender
    task automatic send_idle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Send a word; mid-word request types may be mixed
    task automatic send_word(bit req, byte unsigned w[$], bit mix);
        foreach (w[k]) begin
            if (k == w.size() - 1) send_char(req, w[k], 1'b1);
            else send_char(mix ? 1'($urandom) : req, w[k], 1'b0);
        end
    endtask

    task automatic make_word(output byte unsigned w[$], input int len, input int span);
        w.delete();
        repeat (len) w.push_back(byte'($urandom_range(span)));
    endtask

    task automatic shuffled(input byte unsigned src[$], output byte unsigned w[$]);
        w = src;
        w.shuffle();
    endtask

    initial begin
        byte unsigned w[$];
        byte unsigned v[$];
        int n;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-table query, extremes, zero byte, truncation
        w = '{8'h61};
        send_word(REQ_QUERY, w, 0);
        w = '{8'h00, 8'hFF};
        send_word(REQ_LOAD, w, 0);
        w = '{8'hFF, 8'h00};
        send_word(REQ_QUERY, w, 0);
        w = '{8'h00};
        send_word(REQ_LOAD, w, 0);
        send_word(REQ_QUERY, w, 0);
        w = '{8'h55, 8'hAA, 8'h55};
        send_word(REQ_LOAD, w, 1);
        w = '{8'h55, 8'h55, 8'hAA};
        send_word(REQ_QUERY, w, 1);
        w = '{8'h55, 8'hAA};
        send_word(REQ_QUERY, w, 0);
        make_word(w, 55, 255);
        send_word(REQ_LOAD, w, 0);
        v = w[0:49];
        v.shuffle();
        v.push_back(8'h7E);
        send_word(REQ_QUERY, v, 0);
        send_idle();
        while (sb.pending.size() > 0) @(negedge i_clk);

        // Random: build up the table with anagram families
        stall_mode = 1;
        n = 0;
        while (n < 230) begin
            if (pool.size() == 0 || $urandom_range(2) == 0) begin
                make_word(w, ($urandom_range(7) == 0) ? $urandom_range(52, 1)
                             : $urandom_range(6, 1), ($urandom_range(1)) ? 3 : 255);
                pool.push_back(w);
            end else begin
                shuffled(pool[$urandom_range(pool.size()-1)], w);
            end
            if ($urandom_range(9) == 0) make_word(w, $urandom_range(4, 1), 255);
            send_word($urandom_range(2) == 0 ? REQ_LOAD : REQ_QUERY, w,
                      $urandom_range(5) == 0);
            n += w.size();
            if (n > 115) stall_mode = 2;
        end
        send_idle();

        // Long receiver hold-off while queries keep coming
        while (sb.pending.size() > 0) @(negedge i_clk);
        hold_off = 400;
        stall_mode = 0;
        repeat (4) begin
            shuffled(pool[$urandom_range(pool.size()-1)], w);
            send_word(REQ_QUERY, w, 0);
        end
        send_idle();

        repeat (TAIL_CYCLES) begin
            if (sb.pending.size() == 0) break;
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end
endmodule

/* sim.f */
src/amt_pkg.sv
src/amt_sort_cell.sv
src/anagram_match_table_unit.sv
sim/anagram_match_table_unit_test.sv
